// File: rtl/etrm_pkg.sv
// Shared types, constants and tables for the Euler angle to rotation matrix block.
// Used by every module of the block; depends on nothing.
package etrm_pkg;

  localparam int ANGLE_BITS_DEF      = 16;
  localparam int ENTRY_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STEPS        = 30;
  localparam int Q30_W               = 32;
  localparam int PROD_W              = 2 * Q30_W;
  localparam int ACC_W               = PROD_W + 2;
  localparam int SC_LAT              = CORDIC_STEPS + 2;

  typedef logic signed [Q30_W-1:0] q30_t;
  typedef q30_t mat_t [9];

  localparam q30_t CORDIC_X0 = 32'sd652032874;
  localparam q30_t ONE_Q30   = 32'sd1073741824;

  localparam logic [2:0] ORD_XYZ = 3'd0;
  localparam logic [2:0] ORD_XZY = 3'd1;
  localparam logic [2:0] ORD_YXZ = 3'd2;
  localparam logic [2:0] ORD_YZX = 3'd3;
  localparam logic [2:0] ORD_ZXY = 3'd4;
  localparam logic [2:0] ORD_ZYX = 3'd5;

  localparam q30_t ATAN [CORDIC_STEPS] = '{
    32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
    32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
    32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
    32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
    32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
    32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
  };

endpackage

// File: rtl/euler_to_rotation_matrix.sv
// Top level: Euler angles to 3x3 rotation matrix, fully pipelined.
// Depends on etrm_pkg, etrm_cordic and etrm_matmul.
//
// Usage:
//   Input word: angle_x, angle_y, angle_z (binary angles, a full turn is
//   2^ANGLE_BITS) and axis_order (xyz, xzy, yxz, yzx, zxy, zyx as 0..5).
//   Output word: entry_0..entry_8, column-major, signed with ENTRY_FRAC_BITS
//   fraction bits and clamped to +-1.0, plus order_valid. Codes 6 and 7 give
//   an all-zero matrix with order_valid low.
//   Both channels use valid/stall; a word moves when valid is high and
//   stall is low.
// Pipeline: 38 stages: the CORDIC stages, matrix setup, both matrix
//   products and clamping, in that order; each stage holds its own word.
// Throughput: one word per cycle while the output is not stalled.
// Stall: when the output word is held by out_stall, every stage holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset: clears all stage valid bits; the pipeline comes up empty.
module euler_to_rotation_matrix #(
  parameter int ANGLE_BITS      = etrm_pkg::ANGLE_BITS_DEF,
  parameter int ENTRY_FRAC_BITS = etrm_pkg::ENTRY_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ANGLE_BITS-1:0]        angle_x,
  input  logic [ANGLE_BITS-1:0]        angle_y,
  input  logic [ANGLE_BITS-1:0]        angle_z,
  input  logic [2:0]                   axis_order,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_0,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_1,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_2,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_3,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_4,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_5,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_6,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_7,
  output logic signed [ENTRY_FRAC_BITS+1:0] entry_8,
  output logic                         order_valid
);

  localparam int EW   = ENTRY_FRAC_BITS + 2;
  localparam int SL   = etrm_pkg::SC_LAT;
  localparam int LAT  = SL + 6;
  localparam etrm_pkg::q30_t LIM  = etrm_pkg::Q30_W'(1) <<< ENTRY_FRAC_BITS;
  localparam etrm_pkg::q30_t NLIM = -LIM;

  logic adv;
  logic vld [LAT];
  logic [2:0] ord [SL];
  logic ok_a;
  logic ok_p [4];

  etrm_pkg::q30_t sx, cx, sy, cy, sz, cz;
  etrm_pkg::mat_t rx, ry, rz;
  etrm_pkg::mat_t ma, mb, mc, mc_d1, mc_d2;
  etrm_pkg::mat_t ma_next, mb_next, mc_next;
  etrm_pkg::mat_t mt, mr;
  logic ok_next;
  logic signed [EW-1:0] ent [9];
  logic signed [EW-1:0] sat [9];

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ord[0] <= axis_order;
      for (int i = 1; i < SL; i++) ord[i] <= ord[i-1];
    end
  end

  etrm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_x (
    .clk(clk), .en(adv), .angle(angle_x), .sin_q(sx), .cos_q(cx));
  etrm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_y (
    .clk(clk), .en(adv), .angle(angle_y), .sin_q(sy), .cos_q(cy));
  etrm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_z (
    .clk(clk), .en(adv), .angle(angle_z), .sin_q(sz), .cos_q(cz));

  always_comb begin
    rx = '{etrm_pkg::ONE_Q30, '0, '0, '0, cx, sx, '0, -sx, cx};
    ry = '{cy, '0, -sy, '0, etrm_pkg::ONE_Q30, '0, sy, '0, cy};
    rz = '{cz, sz, '0, -sz, cz, '0, '0, '0, etrm_pkg::ONE_Q30};
    ok_next = 1'b1;
    unique case (ord[SL-1])
      etrm_pkg::ORD_XYZ: begin ma_next = rx; mb_next = ry; mc_next = rz; end
      etrm_pkg::ORD_XZY: begin ma_next = rx; mb_next = rz; mc_next = ry; end
      etrm_pkg::ORD_YXZ: begin ma_next = ry; mb_next = rx; mc_next = rz; end
      etrm_pkg::ORD_YZX: begin ma_next = ry; mb_next = rz; mc_next = rx; end
      etrm_pkg::ORD_ZXY: begin ma_next = rz; mb_next = rx; mc_next = ry; end
      etrm_pkg::ORD_ZYX: begin ma_next = rz; mb_next = ry; mc_next = rx; end
      default: begin
        ma_next = rx; mb_next = ry; mc_next = rz; ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma    <= ma_next;
      mb    <= mb_next;
      mc    <= mc_next;
      mc_d1 <= mc;
      mc_d2 <= mc_d1;
      ok_a  <= ok_next;
      ok_p[0] <= ok_a;
      for (int i = 1; i < 4; i++) ok_p[i] <= ok_p[i-1];
    end
  end

  etrm_matmul #(.SHIFT(30)) u_mul_first (
    .clk(clk), .en(adv), .a(ma), .b(mb), .p(mt));
  etrm_matmul #(.SHIFT(60 - ENTRY_FRAC_BITS)) u_mul_second (
    .clk(clk), .en(adv), .a(mt), .b(mc_d2), .p(mr));

  for (genvar e = 0; e < 9; e++) begin : g_sat
    always_comb begin
      if (!ok_p[3]) begin
        sat[e] = '0;
      end else if (mr[e] > LIM) begin
        sat[e] = EW'(LIM);
      end else if (mr[e] < NLIM) begin
        sat[e] = EW'(NLIM);
      end else begin
        sat[e] = EW'(mr[e]);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ent[e] <= sat[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      order_valid <= ok_p[3];
    end
  end

  assign entry_0 = ent[0];
  assign entry_1 = ent[1];
  assign entry_2 = ent[2];
  assign entry_3 = ent[3];
  assign entry_4 = ent[4];
  assign entry_5 = ent[5];
  assign entry_6 = ent[6];
  assign entry_7 = ent[7];
  assign entry_8 = ent[8];

`ifndef SYNTH
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !order_valid) |-> (entry_0 == '0 && entry_4 == '0 && entry_8 == '0))
    else $error("invalid order word carries a nonzero matrix");

  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_0 <= EW'(LIM) && entry_0 >= EW'(NLIM) &&
                   entry_4 <= EW'(LIM) && entry_4 >= EW'(NLIM)))
    else $error("matrix entry outside clamp range");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(vld[0]) && $stable(vld[SL]) && out_valid))
    else $error("pipeline advanced while output stalled");
`endif

endmodule

// File: rtl/etrm_cordic.sv
// Pipelined sine/cosine unit: one CORDIC step per register stage, Q30 results.
// Depends on etrm_pkg.
module etrm_cordic #(
  parameter int ANGLE_BITS = etrm_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output etrm_pkg::q30_t        sin_q,
  output etrm_pkg::q30_t        cos_q
);

  localparam int N = etrm_pkg::CORDIC_STEPS;

  etrm_pkg::q30_t x [N+1];
  etrm_pkg::q30_t y [N+1];
  etrm_pkg::q30_t z [N+1];
  logic [1:0]     quad [N+1];
  logic [31:0]    a32;

  assign a32 = {angle, {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= etrm_pkg::CORDIC_X0;
      y[0]    <= '0;
      z[0]    <= {2'b00, a32[29:0]};
      quad[0] <= a32[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        quad[i+1] <= quad[i];
        if (!z[i][31]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - etrm_pkg::ATAN[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + etrm_pkg::ATAN[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad[N])
        2'd0: begin cos_q <= x[N];  sin_q <= y[N];  end
        2'd1: begin cos_q <= -y[N]; sin_q <= x[N];  end
        2'd2: begin cos_q <= -x[N]; sin_q <= -y[N]; end
        default: begin cos_q <= y[N]; sin_q <= -x[N]; end
      endcase
    end
  end

endmodule

// File: rtl/etrm_matmul.sv
// Two-stage 3x3 column-major matrix product: registered products, then sum and round.
// Depends on etrm_pkg.
module etrm_matmul #(
  parameter int SHIFT = 30
) (
  input  logic          clk,
  input  logic          en,
  input  etrm_pkg::mat_t a,
  input  etrm_pkg::mat_t b,
  output etrm_pkg::mat_t p
);

  localparam int PW = etrm_pkg::PROD_W;
  localparam int AW = etrm_pkg::ACC_W;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (SHIFT - 1);

  logic signed [PW-1:0] prod [9][3];
  logic signed [AW-1:0] acc  [9];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      for (genvar k = 0; k < 3; k++) begin : g_term
        always_ff @(posedge clk) begin
          if (en) begin
            prod[r+3*c][k] <= a[r+3*k] * b[3*c+k];
          end
        end
      end
    end
  end

  for (genvar e = 0; e < 9; e++) begin : g_sum
    always_comb begin
      acc[e] = AW'(prod[e][0]) + AW'(prod[e][1]) + AW'(prod[e][2]) + HALF;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        p[e] <= etrm_pkg::Q30_W'(acc[e] >>> SHIFT);
      end
    end
  end

endmodule
